// ===== rtl/scp_pkg.sv =====
// shared types and constants for the sexagesimal coordinate parser
// no dependencies; imported by every rtl module of the block

package scp_pkg;

    // field widths
    localparam int DEG_W     = 10;
    localparam int MS_W      = 7;
    localparam int TOTAL_W   = 23;
    localparam int PROD_W    = 22;
    localparam int MS_SUM_W  = 13;

    // queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // arithmetic constants
    localparam int SEC_PER_DEG = 3600;
    localparam int SEC_PER_MIN = 60;

    // character codes
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;

    // one parsed string, handed from front to back
    typedef struct packed {
        logic             neg;
        logic [DEG_W-1:0] deg;
        logic [MS_W-1:0]  min;
        logic [MS_W-1:0]  sec;
        logic             secs_ok;
        logic             bad_deg;
        logic             short_in;
    } rec_t;

endpackage

// ===== rtl/sexagesimal_coord_parser.sv =====
// Sexagesimal coordinate string parser. Takes one character per cycle on the input
// channel while in_ready is high and, for each string whose final character is marked
// by last, delivers one result: signed total seconds plus the seconds-present,
// bad-degree-digit and short-input flags. A result passes the record queue, stage one
// and the output register after its last character is accepted; the front parse state
// machine sustains one character per cycle unless the queue is full. While the output
// is stalled, the two back-end pipeline registers and the QUEUE_DEPTH-entry record
// queue together hold QUEUE_DEPTH + 2 finished strings; once the queue is full, in_ready
// drops for every character. Depends on scp_pkg, scp_front, scp_queue and scp_back.

module sexagesimal_coord_parser #(
    parameter int QUEUE_DEPTH = scp_pkg::QUEUE_DEPTH
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [7:0]                         char_code,
    input  logic                               last,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic signed [scp_pkg::TOTAL_W-1:0] total_seconds,
    output logic                               seconds_present,
    output logic                               bad_degree_digit,
    output logic                               short_input
);
    import scp_pkg::*;

    logic q_full;
    logic push;
    rec_t push_rec;
    logic pop;
    logic q_valid;
    rec_t q_rec;

    // character parser
    scp_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .char_code(char_code),
        .last     (last),
        .q_full   (q_full),
        .push     (push),
        .push_rec (push_rec)
    );

    // record queue
    scp_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .push_rec(push_rec),
        .full    (q_full),
        .pop     (pop),
        .q_valid (q_valid),
        .q_rec   (q_rec)
    );

    // seconds arithmetic
    scp_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .q_valid         (q_valid),
        .q_rec           (q_rec),
        .pop             (pop),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .total_seconds   (total_seconds),
        .seconds_present (seconds_present),
        .bad_degree_digit(bad_degree_digit),
        .short_input     (short_input)
    );

endmodule

// ===== rtl/scp_front.sv =====
// front end: per-character parse state machine, one character per cycle while the queue is not full
// depends on scp_pkg; emits one rec_t per string when the last character arrives

module scp_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [7:0]          char_code,
    input  logic                last,
    input  logic                q_full,
    output logic                push,
    output scp_pkg::rec_t       push_rec
);
    import scp_pkg::*;

    // parse phases
    localparam logic [3:0] PH_START = 4'd0;
    localparam logic [3:0] PH_DEG1  = 4'd1;
    localparam logic [3:0] PH_DEG2  = 4'd2;
    localparam logic [3:0] PH_DEG3  = 4'd3;
    localparam logic [3:0] PH_SEP1  = 4'd4;
    localparam logic [3:0] PH_MIN1  = 4'd5;
    localparam logic [3:0] PH_MIN2D = 4'd6;
    localparam logic [3:0] PH_MIN2S = 4'd7;
    localparam logic [3:0] PH_SEP2  = 4'd8;
    localparam logic [3:0] PH_SEC1  = 4'd9;
    localparam logic [3:0] PH_SEC2D = 4'd10;
    localparam logic [3:0] PH_SEC2S = 4'd11;
    localparam logic [3:0] PH_DONE  = 4'd12;

    logic [3:0]       phase_reg, phase_next;
    logic             neg_reg, neg_next;
    logic [DEG_W-1:0] deg_reg, deg_next;
    logic [MS_W-1:0]  min_reg, min_next;
    logic [MS_W-1:0]  sec_reg, sec_next;
    logic             err_reg, err_next;

    logic             is_dig;
    logic [3:0]       dval;
    logic [3:0]       dval_or_zero;
    logic [DEG_W-1:0] dval_x10;
    logic             take;
    logic             secs_ok;

    // digit decode
    assign is_dig       = (char_code >= CHAR_ZERO) && (char_code <= CHAR_NINE);
    assign dval         = 4'(char_code - CHAR_ZERO);
    assign dval_or_zero = is_dig ? dval : 4'd0;
    assign dval_x10     = ({6'd0, dval_or_zero} << 3) + ({6'd0, dval_or_zero} << 1);

    assign in_ready = !q_full;
    assign take     = in_valid && in_ready;

    // next parse state
    always_comb
    begin
        phase_next = phase_reg;
        neg_next   = neg_reg;
        deg_next   = deg_reg;
        min_next   = min_reg;
        sec_next   = sec_reg;
        err_next   = err_reg;
        case (phase_reg)
            PH_START:
            begin
                if (char_code == CHAR_MINUS || char_code == CHAR_PLUS)
                begin
                    neg_next   = (char_code == CHAR_MINUS);
                    phase_next = PH_DEG1;
                end
                else
                begin
                    deg_next   = dval_x10;
                    err_next   = err_reg | !is_dig;
                    phase_next = PH_DEG2;
                end
            end
            PH_DEG1:
            begin
                deg_next   = dval_x10;
                err_next   = err_reg | !is_dig;
                phase_next = PH_DEG2;
            end
            PH_DEG2:
            begin
                deg_next   = deg_reg + {6'd0, dval_or_zero};
                err_next   = err_reg | !is_dig;
                phase_next = PH_DEG3;
            end
            PH_DEG3:
            begin
                if (is_dig)
                begin
                    deg_next   = (deg_reg << 3) + (deg_reg << 1) + {6'd0, dval};
                    phase_next = PH_SEP1;
                end
                else
                begin
                    phase_next = PH_MIN1;
                end
            end
            PH_SEP1:
            begin
                phase_next = PH_MIN1;
            end
            PH_MIN1:
            begin
                if (is_dig)
                begin
                    min_next   = {3'd0, dval};
                    phase_next = PH_MIN2D;
                end
                else
                begin
                    min_next   = '0;
                    phase_next = PH_MIN2S;
                end
            end
            PH_MIN2D:
            begin
                if (is_dig)
                begin
                    min_next = (min_reg << 3) + (min_reg << 1) + {3'd0, dval};
                end
                phase_next = PH_SEP2;
            end
            PH_MIN2S:
            begin
                phase_next = PH_SEP2;
            end
            PH_SEP2:
            begin
                phase_next = PH_SEC1;
            end
            PH_SEC1:
            begin
                if (is_dig)
                begin
                    sec_next   = {3'd0, dval};
                    phase_next = PH_SEC2D;
                end
                else
                begin
                    sec_next   = '0;
                    phase_next = PH_SEC2S;
                end
            end
            PH_SEC2D:
            begin
                if (is_dig)
                begin
                    sec_next = (sec_reg << 3) + (sec_reg << 1) + {3'd0, dval};
                end
                phase_next = PH_DONE;
            end
            PH_SEC2S:
            begin
                phase_next = PH_DONE;
            end
            default:
            begin
                phase_next = phase_reg;
            end
        endcase
    end

    // record for the back end, built from the updated state
    assign secs_ok = (phase_next >= PH_DONE);

    always_comb
    begin
        push_rec.neg      = neg_next;
        push_rec.deg      = deg_next;
        push_rec.min      = min_next;
        push_rec.sec      = secs_ok ? sec_next : '0;
        push_rec.secs_ok  = secs_ok;
        push_rec.bad_deg  = err_next;
        push_rec.short_in = (phase_next < PH_SEP2);
    end

    assign push = take && last;

    // parse state, cleared after the last character of a string
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_START;
            neg_reg   <= 1'b0;
            deg_reg   <= '0;
            min_reg   <= '0;
            sec_reg   <= '0;
            err_reg   <= 1'b0;
        end
        else if (take)
        begin
            if (last)
            begin
                phase_reg <= PH_START;
                neg_reg   <= 1'b0;
                deg_reg   <= '0;
                min_reg   <= '0;
                sec_reg   <= '0;
                err_reg   <= 1'b0;
            end
            else
            begin
                phase_reg <= phase_next;
                neg_reg   <= neg_next;
                deg_reg   <= deg_next;
                min_reg   <= min_next;
                sec_reg   <= sec_next;
                err_reg   <= err_next;
            end
        end
    end

endmodule

// ===== rtl/scp_queue.sv =====
// short fifo of parsed records between front and back end
// depends on scp_pkg for rec_t

module scp_queue #(
    parameter int DEPTH = scp_pkg::QUEUE_DEPTH
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  scp_pkg::rec_t push_rec,
    output logic          full,
    input  logic          pop,
    output logic          q_valid,
    output scp_pkg::rec_t q_rec
);
    import scp_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    rec_t             entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign q_valid = (count_reg != '0);
    assign q_rec   = entry_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && q_valid;

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_rec;
        end
    end

endmodule

// ===== rtl/scp_back.sv =====
// back end: two-stage arithmetic pipeline turning a record into signed seconds
// depends on scp_pkg; stage one forms the products, stage two sums and applies the sign

module scp_back (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               q_valid,
    input  scp_pkg::rec_t                      q_rec,
    output logic                               pop,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic signed [scp_pkg::TOTAL_W-1:0] total_seconds,
    output logic                               seconds_present,
    output logic                               bad_degree_digit,
    output logic                               short_input
);
    import scp_pkg::*;

    // stage one
    logic                s1_valid_reg;
    logic [PROD_W-1:0]   s1_deg_prod_reg;
    logic [MS_SUM_W-1:0] s1_ms_reg;
    logic                s1_neg_reg;
    logic                s1_secs_ok_reg;
    logic                s1_bad_reg;
    logic                s1_short_reg;

    // output stage
    logic                out_valid_reg;
    logic [TOTAL_W-1:0]  total_reg;
    logic                secs_ok_reg;
    logic                bad_reg;
    logic                short_reg;

    logic                s1_adv;
    logic                s1_take;
    logic [PROD_W-1:0]   mag;
    logic [TOTAL_W-1:0]  mag_ext;
    logic [TOTAL_W-1:0]  total_next;

    // pipeline flow control
    assign s1_adv  = !out_valid_reg || out_ready;
    assign s1_take = !s1_valid_reg || s1_adv;
    assign pop     = q_valid && s1_take;

    // sum and sign
    assign mag        = s1_deg_prod_reg + PROD_W'(s1_ms_reg);
    assign mag_ext    = {1'b0, mag};
    assign total_next = s1_neg_reg ? (~mag_ext + 1'b1) : mag_ext;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_take)
            begin
                s1_valid_reg <= q_valid;
            end
            if (s1_adv)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    // stage one products
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            s1_deg_prod_reg <= PROD_W'(q_rec.deg) * PROD_W'(SEC_PER_DEG);
            s1_ms_reg       <= MS_SUM_W'(q_rec.min) * MS_SUM_W'(SEC_PER_MIN)
                             + MS_SUM_W'(q_rec.sec);
            s1_neg_reg      <= q_rec.neg;
            s1_secs_ok_reg  <= q_rec.secs_ok;
            s1_bad_reg      <= q_rec.bad_deg;
            s1_short_reg    <= q_rec.short_in;
        end
    end

    // output register
    always_ff @(posedge clk)
    begin
        if (s1_valid_reg && s1_adv)
        begin
            total_reg   <= total_next;
            secs_ok_reg <= s1_secs_ok_reg;
            bad_reg     <= s1_bad_reg;
            short_reg   <= s1_short_reg;
        end
    end

    assign out_valid        = out_valid_reg;
    assign total_seconds    = total_reg;
    assign seconds_present  = secs_ok_reg;
    assign bad_degree_digit = bad_reg;
    assign short_input      = short_reg;

endmodule

// ===== rtl/scp_checker.sv =====
// port-level checks for the sexagesimal coordinate parser
// depends on scp_pkg; bound to sexagesimal_coord_parser at the end of this file

module scp_checker (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               out_valid,
    input logic                               out_ready,
    input logic signed [scp_pkg::TOTAL_W-1:0] total_seconds,
    input logic                               seconds_present,
    input logic                               short_input
);
    import scp_pkg::*;

    // a stalled request holds its value
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(total_seconds))
        else $error("output request changed while stalled");

    // seconds can only be present when the minutes were complete
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && seconds_present |-> !short_input)
        else $error("seconds present on a short string");

    // magnitude stays within three-digit degrees and two-digit fields
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (total_seconds <= 23'sd3602439) && (total_seconds >= -23'sd3602439))
        else $error("total seconds out of range");

    // a short string never carries a seconds field, checked only when short_input has just changed
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && short_input |-> !seconds_present || $stable(short_input))
        else $error("short string with seconds");

endmodule

bind sexagesimal_coord_parser scp_checker u_scp_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .total_seconds  (total_seconds),
    .seconds_present(seconds_present),
    .short_input    (short_input)
);
